// ----- rtl/ebcfc_pkg.sv -----
// shared types, codes and the assist level table for the e-bike CAN frame codec
// no dependencies; used by every module
`default_nettype none

package ebcfc_pkg;

    // frame identifiers
    localparam logic [28:0] ID_TORQUE = 29'h01F83100;
    localparam logic [28:0] ID_CHARGE = 29'h02F83200;
    localparam logic [28:0] ID_MOTION = 29'h02F83201;
    localparam logic [28:0] ID_WHEEL  = 29'h02F83203;
    localparam logic [28:0] ID_BRAKE  = 29'h02FF1200;

    localparam logic [7:0] WALK_CODE = 8'h06;

    // message kinds
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_TORQUE = 3'd1;
    localparam logic [2:0] KIND_CHARGE = 3'd2;
    localparam logic [2:0] KIND_MOTION = 3'd3;
    localparam logic [2:0] KIND_WHEEL  = 3'd4;
    localparam logic [2:0] KIND_BRAKE  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_LEVEL_COUNT = 2'd0;
    localparam logic [1:0] CFG_WALK_ALLOW  = 2'd1;
    localparam logic [1:0] CFG_KA_PERIOD   = 2'd2;

    localparam logic [3:0]  RST_LEVEL_COUNT = 4'd5;
    localparam logic [15:0] RST_KA_PERIOD   = 16'd100;

    // reciprocal of ten: (x * RECIP10) >> 19 == x / 10 for any 16-bit x
    localparam logic [16:0] RECIP10       = 17'd52429;
    localparam int          RECIP10_SHIFT = 19;

    typedef struct packed {
        logic [31:0] time_now_ms;
        logic [3:0]  assist_level;
        logic        walk_assist;
        logic        lights;
        logic        up_down_long_click;
        logic        onoff_event;
        logic        frame_valid;
        logic [28:0] frame_id;
        logic [63:0] frame_data;
    } t_in_item;

    typedef struct packed {
        logic        keepalive_valid;
        logic [31:0] keepalive_payload;
    } t_ka;

    typedef struct packed {
        logic [2:0]  message_kind;
        logic [15:0] value_a;
        logic [15:0] value_b;
        logic [15:0] value_c;
        logic [7:0]  value_d;
        logic        motion_seen;
    } t_frame;

    function automatic logic [7:0] level_code(input logic [3:0] count,
                                              input logic [3:0] level);
        logic [7:0] code;
        code = 8'h00;
        case (count)
            4'd3: begin
                case (level)
                    4'd1:    code = 8'h0C;
                    4'd2:    code = 8'h02;
                    4'd3:    code = 8'h03;
                    default: code = 8'h00;
                endcase
            end
            4'd5: begin
                case (level)
                    4'd1:    code = 8'h0B;
                    4'd2:    code = 8'h0D;
                    4'd3:    code = 8'h15;
                    4'd4:    code = 8'h17;
                    4'd5:    code = 8'h03;
                    default: code = 8'h00;
                endcase
            end
            4'd9: begin
                case (level)
                    4'd1:    code = 8'h01;
                    4'd2:    code = 8'h0B;
                    4'd3:    code = 8'h0C;
                    4'd4:    code = 8'h0D;
                    4'd5:    code = 8'h02;
                    4'd6:    code = 8'h15;
                    4'd7:    code = 8'h16;
                    4'd8:    code = 8'h17;
                    4'd9:    code = 8'h03;
                    default: code = 8'h00;
                endcase
            end
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ebcfc_in_if.sv -----
// input channel: one poll transaction per handshake
// no dependencies
`default_nettype none

interface ebcfc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] time_now_ms;
    logic [3:0]  assist_level;
    logic        walk_assist;
    logic        lights;
    logic        up_down_long_click;
    logic        onoff_event;
    logic        frame_valid;
    logic [28:0] frame_id;
    logic [63:0] frame_data;

    modport source (
        output valid, time_now_ms, assist_level, walk_assist, lights,
               up_down_long_click, onoff_event, frame_valid, frame_id, frame_data,
        input  ready
    );
    modport sink (
        input  valid, time_now_ms, assist_level, walk_assist, lights,
               up_down_long_click, onoff_event, frame_valid, frame_id, frame_data,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/ebcfc_out_if.sv -----
// result channel: one result transaction per poll
// no dependencies
`default_nettype none

interface ebcfc_out_if;
    logic        valid;
    logic        ready;
    logic        keepalive_valid;
    logic [31:0] keepalive_payload;
    logic [2:0]  message_kind;
    logic [15:0] value_a;
    logic [15:0] value_b;
    logic [15:0] value_c;
    logic [7:0]  value_d;
    logic        motor_ready;

    modport source (
        output valid, keepalive_valid, keepalive_payload, message_kind,
               value_a, value_b, value_c, value_d, motor_ready,
        input  ready
    );
    modport sink (
        input  valid, keepalive_valid, keepalive_payload, message_kind,
               value_a, value_b, value_c, value_d, motor_ready,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/ebike_can_frame_codec.sv -----
// e-bike CAN frame codec top level: config registers, input and result registers
// depends on ebcfc_pkg, ebcfc_in_if, ebcfc_out_if, ebcfc_keepalive, ebcfc_frame_dec
//
//  channel    | direction | handshake     | carries
//  -----------+-----------+---------------+--------------------------------------
//  i_item     | in        | valid/ready   | poll: time, ui inputs, optional frame
//  o_result   | out       | valid/ready   | keep-alive payload, decoded values
//  i_cfg_*    | in        | write enable  | level count, walk allow, period
//
//  one transaction per clock sustained while results are taken; a poll passes the input
//  register, then decode and keep-alive check into the result register
//  keep-alive time and motor-ready flag update when a poll moves into the
//  result register, so consecutive polls see each other's state
//  a stalled result holds; one more poll waits in the input register
//  synchronous active-low reset clears valids, state and config to defaults
`default_nettype none

module ebike_can_frame_codec
    import ebcfc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_wdata,
    ebcfc_in_if.sink         i_item,
    ebcfc_out_if.source      o_result
);

    logic [3:0]  r_level_count;
    logic        r_walk_allowed;
    logic [15:0] r_period;

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    logic        r_motor_ready;
    t_ka         r_ka;
    t_frame      r_frame;

    logic        n_motor_ready;
    logic        advance;
    logic        in_take;
    logic        fire;
    t_in_item    in_item;
    t_ka         ka;
    t_frame      frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_count  <= RST_LEVEL_COUNT;
            r_walk_allowed <= 1'b0;
            r_period       <= RST_KA_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEVEL_COUNT: r_level_count  <= i_cfg_wdata[3:0];
                CFG_WALK_ALLOW:  r_walk_allowed <= i_cfg_wdata[0];
                CFG_KA_PERIOD:   r_period       <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign advance = !r_out_valid || o_result.ready;
    assign fire    = r_in_valid && advance;
    assign i_item.ready = !r_in_valid || advance;
    assign in_take = i_item.valid && i_item.ready;

    assign in_item.time_now_ms        = i_item.time_now_ms;
    assign in_item.assist_level       = i_item.assist_level;
    assign in_item.walk_assist        = i_item.walk_assist;
    assign in_item.lights             = i_item.lights;
    assign in_item.up_down_long_click = i_item.up_down_long_click;
    assign in_item.onoff_event        = i_item.onoff_event;
    assign in_item.frame_valid        = i_item.frame_valid;
    assign in_item.frame_id           = i_item.frame_id;
    assign in_item.frame_data         = i_item.frame_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= in_item;
        end
    end

    ebcfc_keepalive u_keepalive (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_item         (r_in),
        .i_level_count  (r_level_count),
        .i_walk_allowed (r_walk_allowed),
        .i_period       (r_period),
        .o_ka           (ka)
    );

    ebcfc_frame_dec u_frame_dec (
        .i_item  (r_in),
        .o_frame (frame)
    );

    assign n_motor_ready = r_motor_ready || (fire && frame.motion_seen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_motor_ready <= 1'b0;
        end else begin
            r_motor_ready <= n_motor_ready;
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_ka    <= ka;
            r_frame <= frame;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.keepalive_valid   = r_ka.keepalive_valid;
    assign o_result.keepalive_payload = r_ka.keepalive_payload;
    assign o_result.message_kind      = r_frame.message_kind;
    assign o_result.value_a           = r_frame.value_a;
    assign o_result.value_b           = r_frame.value_b;
    assign o_result.value_c           = r_frame.value_c;
    assign o_result.value_d           = r_frame.value_d;
    // flag as it stood right after this transaction
    assign o_result.motor_ready       = r_motor_ready;

    // motor-ready flag is sticky once set
    a_motor_ready_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_motor_ready |=> r_motor_ready)
        else $error("motor ready flag dropped");

    // a motion result always reports the motor as ready
    a_motion_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.message_kind == KIND_MOTION) |-> o_result.motor_ready)
        else $error("motion result without motor ready");

    // no keep-alive means an empty payload
    a_ka_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.keepalive_valid) |-> (o_result.keepalive_payload == 32'd0))
        else $error("payload present without keep-alive");

    // both stages full and result stalled: no room for another poll
    a_full_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_result.ready) |-> !i_item.ready)
        else $error("poll accepted while pipeline full");

endmodule

`default_nettype wire

// ----- rtl/ebcfc_keepalive.sv -----
// keep-alive timer and payload builder; holds the last send time
// depends on ebcfc_pkg
`default_nettype none

module ebcfc_keepalive
    import ebcfc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire t_in_item    i_item,
    input  wire logic [3:0]  i_level_count,
    input  wire logic        i_walk_allowed,
    input  wire logic [15:0] i_period,
    output t_ka              o_ka
);

    logic [31:0] r_last_send;
    logic [31:0] n_last_send;
    logic [31:0] elapsed;
    logic        due;
    logic [7:0]  code;

    assign elapsed = i_item.time_now_ms - r_last_send;
    assign due     = elapsed >= {16'd0, i_period};

    always_comb begin
        code = level_code(i_level_count, i_item.assist_level);
        if (i_walk_allowed && i_item.walk_assist) begin
            code = WALK_CODE;
        end
        o_ka.keepalive_valid   = due;
        o_ka.keepalive_payload = 32'd0;
        if (due) begin
            o_ka.keepalive_payload = {7'd0, !i_item.onoff_event,
                                      6'd0, i_item.up_down_long_click, i_item.lights,
                                      code,
                                      4'd0, i_level_count};
        end
    end

    assign n_last_send = (i_fire && due) ? i_item.time_now_ms : r_last_send;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_send <= 32'd0;
        end else begin
            r_last_send <= n_last_send;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ebcfc_frame_dec.sv -----
// received frame decoder: identifier match and per-kind value extraction
// depends on ebcfc_pkg
`default_nettype none

module ebcfc_frame_dec
    import ebcfc_pkg::*;
(
    input  wire t_in_item i_item,
    output t_frame        o_frame
);

    logic [15:0] half0;
    logic [15:0] half2;
    logic [15:0] half4;
    logic [7:0]  byte0;
    logic [7:0]  byte2;
    logic [7:0]  byte7;
    logic [32:0] prod_speed;
    logic [32:0] prod_curr;
    logic [15:0] speed_div10;
    logic [15:0] curr_div10;
    logic [11:0] wheel_hi;
    logic [15:0] wheel_size;

    assign byte0 = i_item.frame_data[7:0];
    assign byte2 = i_item.frame_data[23:16];
    assign byte7 = i_item.frame_data[63:56];
    assign half0 = i_item.frame_data[15:0];
    assign half2 = i_item.frame_data[31:16];
    assign half4 = i_item.frame_data[47:32];

    // divide by ten through the reciprocal; /20 is (/10) halved
    // quotient of a 16-bit value by ten fits in the top fourteen product bits
    assign prod_speed  = {17'd0, half0} * {16'd0, RECIP10};
    assign prod_curr   = {17'd0, half2} * {16'd0, RECIP10};
    assign speed_div10 = {2'd0, prod_speed[RECIP10_SHIFT +: 14]};
    assign curr_div10  = {2'd0, prod_curr[RECIP10_SHIFT +: 14]};

    // upper twelve bits times ten as shift and add, plus the low nibble
    assign wheel_hi   = half2[15:4];
    assign wheel_size = {1'b0, wheel_hi, 3'd0} + {3'd0, wheel_hi, 1'b0}
                      + {12'd0, byte2[3:0]};

    always_comb begin
        o_frame = '0;
        if (i_item.frame_valid) begin
            case (i_item.frame_id)
                ID_TORQUE: begin
                    o_frame.message_kind = KIND_TORQUE;
                    o_frame.value_a      = half0;
                    o_frame.value_b      = {8'd0, byte2};
                end
                ID_CHARGE: begin
                    o_frame.message_kind = KIND_CHARGE;
                    o_frame.value_a      = {8'd0, byte0};
                end
                ID_MOTION: begin
                    o_frame.message_kind = KIND_MOTION;
                    o_frame.motion_seen  = 1'b1;
                    o_frame.value_a      = speed_div10;
                    o_frame.value_b      = {8'd0, curr_div10[8:1]};
                    o_frame.value_c      = half4;
                    o_frame.value_d      = byte7 - 8'd40;
                end
                ID_WHEEL: begin
                    o_frame.message_kind = KIND_WHEEL;
                    o_frame.value_a      = half0;
                    o_frame.value_b      = wheel_size;
                    o_frame.value_c      = half4;
                end
                ID_BRAKE: begin
                    o_frame.message_kind = KIND_BRAKE;
                    o_frame.value_a      = {15'd0, byte0[0]};
                end
                default: begin
                    o_frame = '0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
